@@ design/shl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shl_pkg
// Types and constants shared by the heard-table cells and the top level.
// ----------------------------------------------------------------------------
package shl_pkg;

    typedef struct packed {
        logic        kind;
        logic [31:0] now_seconds;
        logic [55:0] source_addr;
        logic [55:0] dest_addr;
        logic [2:0]  frame_class;
        logic [7:0]  control_byte;
        logic [7:0]  pid;
        logic [8:0]  data_length;
        logic [63:0] data_head;
        logic [3:0]  digi_count;
        logic [15:0] frame_crc;
        logic        dest_is_bulletin;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  entry_index;
        logic        created;
        logic        evicted;
        logic [31:0] packet_count;
        logic [31:0] byte_count;
        logic [8:0]  station_flags;
        logic [7:0]  duplicate_count;
        logic [3:0]  send_seq;
        logic [3:0]  recv_seq;
        logic [6:0]  cleared_count;
    } out_item_t;

    // entry state except the address key
    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] packets;
        logic [31:0] bytes;
        logic [8:0]  flags;
        logic [2:0]  cls;
        logic [15:0] crc;
        logic [7:0]  dups;
        logic [7:0]  seqs;
    } entry_stat_t;

    typedef struct packed {
        logic [55:0] src;
        logic [55:0] dst;
        entry_stat_t stat;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_SWEEP,
        ST_OUT
    } state_t;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_SWEEP  = 1'b1;

    localparam logic [2:0] CLS_I     = 3'd0;
    localparam logic [2:0] CLS_UI    = 3'd1;
    localparam logic [2:0] CLS_RR    = 3'd2;
    localparam logic [2:0] CLS_DISC  = 3'd3;
    localparam logic [2:0] CLS_OTHER = 3'd4;

    localparam int FL_INFO   = 0;
    localparam int FL_NETROM = 1;
    localparam int FL_ARP    = 2;
    localparam int FL_IP     = 3;
    localparam int FL_DIRECT = 4;
    localparam int FL_CODE   = 5;
    localparam int FL_BIN    = 6;
    localparam int FL_MAIL   = 7;
    localparam int FL_BULL   = 8;

    localparam logic [2:0] REG_STALE      = 3'd0;
    localparam logic [2:0] REG_DISC_STALE = 3'd1;
    localparam logic [2:0] REG_PID_NETROM = 3'd2;
    localparam logic [2:0] REG_PID_ARP    = 3'd3;
    localparam logic [2:0] REG_PID_IP     = 3'd4;

    localparam logic [47:0] TXT_CODE = 48'h2F2F434F4445;     // "//CODE"
    localparam logic [39:0] TXT_BIN  = 40'h2342494E23;       // "#BIN#"
    localparam logic [63:0] TXT_MAIL = 64'h4D61696C20666F72; // "Mail for"

    localparam entry_stat_t STAT_RESET = '{
        stamp: 32'd0, packets: 32'd0, bytes: 32'd0, flags: 9'd0,
        cls: CLS_OTHER, crc: 16'd0, dups: 8'd0, seqs: 8'hFF};

endpackage

@@ design/shl_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shl_cell
// One table entry; passes its contents to the neighbor on every shift.
// ----------------------------------------------------------------------------
module shl_cell
    import shl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  entry_t d,
    output entry_t q
);

    logic [55:0] src_reg;
    logic [55:0] dst_reg;
    entry_stat_t stat_reg;

    // key is only read for non-empty entries
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            src_reg <= d.src;
            dst_reg <= d.dst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stat_reg <= STAT_RESET;
        else if (shift)
            stat_reg <= d.stat;
    end

    assign q.src  = src_reg;
    assign q.dst  = dst_reg;
    assign q.stat = stat_reg;

endmodule

@@ design/station_heard_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// station_heard_table
// Heard-station table kept in a rotating ring of entry cells.
// ----------------------------------------------------------------------------
// Packet transaction: one ring rotation to search, one to write the chosen
// entry back; the result is then held on out_valid until it is taken.
// Sweep transaction: one ring rotation; the result is then held the same way.
// One transaction at a time: in_stall stays high from accept until the
// result is taken without an output stall and the control returns to idle.
// Reset empties every entry and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module station_heard_table
    import shl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int XW = (IW > 6) ? IW : 6;
    localparam int NW = (IW + 1 > 8) ? IW + 1 : 8;
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    // configuration registers
    logic [31:0] stale_reg;
    logic [31:0] disc_stale_reg;
    logic [7:0]  pid_netrom_reg;
    logic [7:0]  pid_arp_reg;
    logic [7:0]  pid_ip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg      <= 32'd600;
            disc_stale_reg <= 32'd60;
            pid_netrom_reg <= 8'd207;
            pid_arp_reg    <= 8'd205;
            pid_ip_reg     <= 8'd204;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_STALE:      stale_reg      <= cfg_wdata;
                REG_DISC_STALE: disc_stale_reg <= cfg_wdata;
                REG_PID_NETROM: pid_netrom_reg <= cfg_wdata[7:0];
                REG_PID_ARP:    pid_arp_reg    <= cfg_wdata[7:0];
                REG_PID_IP:     pid_ip_reg     <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // control
    state_t state_reg, state_next;
    logic [IW-1:0] cnt_reg;
    in_item_t item_reg;

    logic ring_shift;
    logic cnt_last;
    logic in_accept;
    logic cnt_clear;

    assign in_accept  = in_valid && !in_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign cnt_last   = (cnt_reg == LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ring_shift = 1'b0;
        cnt_clear  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_clear = 1'b1;
                if (in_valid)
                    state_next = (in_data.kind == KIND_SWEEP) ? ST_SWEEP : ST_SCAN;
            end
            ST_SCAN:
            begin
                ring_shift = 1'b1;
                cnt_clear  = cnt_last;
                if (cnt_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE, ST_SWEEP:
            begin
                ring_shift = 1'b1;
                if (cnt_last)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cnt_clear)
            cnt_reg <= '0;
        else if (ring_shift)
            cnt_reg <= cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            item_reg <= in_data;
    end

    // ring of cells; cell 0 is the head, its next contents come from cell 1
    entry_t cell_q [TABLE_ENTRIES];
    entry_t head_mod;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            entry_t cell_d;
            if (gi == TABLE_ENTRIES - 1)
            begin : g_tail
                assign cell_d = head_mod;
            end
            else
            begin : g_mid
                assign cell_d = cell_q[gi+1];
            end
            shl_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (ring_shift),
                .d     (cell_d),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    entry_t head;
    assign head = cell_q[0];

    // search pass: first hit, first empty, oldest (lowest index on a tie)
    logic          hit_found_reg, empty_found_reg;
    logic [IW-1:0] hit_idx_reg, empty_idx_reg, old_idx_reg;
    logic [31:0]   old_time_reg;
    logic [IW-1:0] tgt_reg;
    logic          created_reg, evicted_reg;

    logic head_busy;
    logic head_hit;
    assign head_busy = (head.stat.packets != 32'd0);
    assign head_hit  = head_busy && (head.src == item_reg.source_addr)
                       && (head.dst == item_reg.dest_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            created_reg     <= 1'b0;
            evicted_reg     <= 1'b0;
        end
        else if (state_reg == ST_IDLE)
        begin
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (head_hit && !hit_found_reg)
                hit_found_reg <= 1'b1;
            if (!head_busy && !empty_found_reg)
                empty_found_reg <= 1'b1;
            if (cnt_last)
            begin
                created_reg <= !(hit_found_reg || head_hit);
                evicted_reg <= !(hit_found_reg || head_hit)
                               && !(empty_found_reg || !head_busy);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN)
        begin
            if (head_hit && !hit_found_reg)
                hit_idx_reg <= cnt_reg;
            if (!head_busy && !empty_found_reg)
                empty_idx_reg <= cnt_reg;
            if (cnt_reg == '0 || head.stat.stamp < old_time_reg)
            begin
                old_idx_reg  <= cnt_reg;
                old_time_reg <= head.stat.stamp;
            end
            if (cnt_last)
            begin
                priority if (hit_found_reg)
                    tgt_reg <= hit_idx_reg;
                else if (head_hit)
                    tgt_reg <= cnt_reg;
                else if (empty_found_reg)
                    tgt_reg <= empty_idx_reg;
                else if (!head_busy)
                    tgt_reg <= cnt_reg;
                else if (head.stat.stamp < old_time_reg)
                    tgt_reg <= cnt_reg;
                else
                    tgt_reg <= old_idx_reg;
            end
        end
    end

    // packet update of the head entry
    entry_t base;
    entry_t upd;
    logic        is_info;
    logic [32:0] byte_sum;
    logic [8:0]  fl;
    logic [2:0]  nr, ns;

    always_comb
    begin
        base = head;
        if (created_reg)
        begin
            base.src          = item_reg.source_addr;
            base.dst          = item_reg.dest_addr;
            base.stat.bytes   = 32'd0;
            base.stat.packets = 32'd0;
            base.stat.flags   = 9'd0;
            base.stat.seqs    = 8'hFF;
            base.stat.dups    = 8'd0;
            base.stat.crc     = 16'd0;
        end
        upd = base;
        upd.stat.stamp = item_reg.now_seconds;
        if (base.stat.packets != 32'hFFFF_FFFF)
            upd.stat.packets = base.stat.packets + 32'd1;
        upd.stat.cls = item_reg.frame_class;

        is_info  = (item_reg.frame_class == CLS_I) || (item_reg.frame_class == CLS_UI);
        byte_sum = {1'b0, base.stat.bytes} + 33'(item_reg.data_length);
        fl       = base.stat.flags;
        nr       = item_reg.control_byte[7:5];
        ns       = item_reg.control_byte[3:1];

        if (is_info)
        begin
            upd.stat.bytes = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
            fl[FL_INFO] = 1'b1;
            priority if (item_reg.pid == pid_netrom_reg)
                fl[FL_NETROM] = 1'b1;
            else if (item_reg.pid == pid_arp_reg)
                fl[FL_ARP] = 1'b1;
            else if (item_reg.pid == pid_ip_reg)
                fl[FL_IP] = 1'b1;
            else
                fl = fl;
        end
        if (item_reg.digi_count == 4'd0)
            fl[FL_DIRECT] = 1'b1;
        if (item_reg.data_length >= 9'd7 && item_reg.data_head[63:16] == TXT_CODE)
            fl[FL_CODE] = 1'b1;
        if (item_reg.data_length >= 9'd5 && item_reg.data_head[63:24] == TXT_BIN)
            fl[FL_BIN] = 1'b1;
        if (item_reg.data_length >= 9'd5 && item_reg.data_head == TXT_MAIL)
            fl[FL_MAIL] = 1'b1;
        if (item_reg.dest_is_bulletin)
            fl[FL_BULL] = 1'b1;
        upd.stat.flags = fl;

        if (item_reg.frame_class == CLS_RR)
            upd.stat.seqs = {1'b0, nr, base.stat.seqs[3:0]};
        if (is_info)
        begin
            if (base.stat.crc != 16'd0 && base.stat.crc == item_reg.frame_crc)
            begin
                if (base.stat.dups != 8'hFF)
                    upd.stat.dups = base.stat.dups + 8'd1;
            end
            else
            begin
                upd.stat.crc  = item_reg.frame_crc;
                upd.stat.dups = 8'd0;
            end
            upd.stat.seqs = {1'b0, nr, 1'b0, ns};
        end
    end

    // sweep of the head entry: general limit, then the disconnect limit
    logic [31:0] age;
    logic        stale;
    entry_t      swept;

    always_comb
    begin
        age   = (item_reg.now_seconds >= head.stat.stamp)
                ? item_reg.now_seconds - head.stat.stamp : 32'd0;
        stale = (age > stale_reg)
                || (head.stat.cls == CLS_DISC && age > disc_stale_reg);
        swept = head;
        if (stale)
            swept.stat.packets = 32'd0;
    end

    logic upd_here;
    assign upd_here = (state_reg == ST_UPDATE) && (cnt_reg == tgt_reg);

    always_comb
    begin
        priority if (upd_here)
            head_mod = upd;
        else if (state_reg == ST_SWEEP)
            head_mod = swept;
        else
            head_mod = head;
    end

    // cleared counter
    logic [NW-1:0] cleared_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cleared_reg <= '0;
        else if (state_reg == ST_IDLE)
            cleared_reg <= '0;
        else if (state_reg == ST_SWEEP && stale && head_busy)
            cleared_reg <= cleared_reg + 1'b1;
    end

    // sweep result: only the cleared count is nonzero, saturating at 127
    logic [NW-1:0] cleared_total;
    out_item_t     sweep_res;

    always_comb
    begin
        cleared_total = cleared_reg + NW'(stale && head_busy);
        sweep_res     = '0;
        if (cleared_total > NW'(127))
            sweep_res.cleared_count = 7'd127;
        else
            sweep_res.cleared_count = 7'(cleared_total);
    end

    // result register
    out_item_t     out_reg;
    logic [XW-1:0] tgt_x;
    assign tgt_x = XW'(tgt_reg);

    always_ff @(posedge clk)
    begin
        if (upd_here)
        begin
            out_reg.entry_index     <= tgt_x[5:0];
            out_reg.created         <= created_reg;
            out_reg.evicted         <= evicted_reg;
            out_reg.packet_count    <= upd.stat.packets;
            out_reg.byte_count      <= upd.stat.bytes;
            out_reg.station_flags   <= upd.stat.flags;
            out_reg.duplicate_count <= upd.stat.dups;
            out_reg.send_seq        <= upd.stat.seqs[3:0];
            out_reg.recv_seq        <= upd.stat.seqs[7:4];
            out_reg.cleared_count   <= 7'd0;
        end
        else if (state_reg == ST_SWEEP && cnt_last)
        begin
            out_reg <= sweep_res;
        end
    end

    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = out_reg;

    // checks
    a_scan_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cnt_last) |=> (state_reg == ST_UPDATE))
        else $error("search pass did not hand over to write-back");

    a_evict_implies_create: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.evicted || out_data.created))
        else $error("eviction without entry setup");

    a_packet_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.cleared_count != 7'd0)
        |-> (out_data.packet_count == 32'd0 && !out_data.created))
        else $error("sweep result carries packet fields");

    a_update_once: assert property (@(posedge clk) disable iff (!rst_n)
        upd_here |=> !upd_here)
        else $error("entry written twice in one pass");

endmodule
